[hw/rtl/cdfs_pkg.sv]
package cdfs_pkg;

  // Table geometry and weight format.
  localparam int MAX_ENTRIES = 1024;
  localparam int WEIGHT_BITS = 32;

  localparam int IDX_W    = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W   = IDX_W + 1;
  localparam int TOTAL_W  = 41;
  localparam int ADDEND_W = WEIGHT_BITS - 1;
  localparam int UNI_W    = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Function codes.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        func;
    logic        table_sel;
    logic        restart;
    logic [31:0] weight;
    logic [31:0] uniform;
  } req_t;

  typedef struct packed {
    logic [9:0]  index;
    logic [40:0] total;
    logic [1:0]  status;
  } rsp_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    logic                func;
    logic                table_sel;
    logic                restart;
    logic [ADDEND_W-1:0] addend;
    logic [UNI_W-1:0]    uniform;
  } cmd_t;

endpackage

[hw/rtl/cdfs_ram.sv]
module cdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/cdfs_queue.sv]
module cdfs_queue
  import cdfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign full       = (fill == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/cdfs_front.sv]
module cdfs_front
  import cdfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic push,
  output cmd_t push_cmd,
  input  logic q_full
);

  logic                held;
  cmd_t                cmd;
  cmd_t                cmd_next;
  logic [WEIGHT_BITS-1:0] w;
  logic                take;

  // A weight with its sign bit set, or zero, contributes nothing.
  always_comb begin
    w                  = req.weight[WEIGHT_BITS-1:0];
    cmd_next.func      = req.func;
    cmd_next.table_sel = req.table_sel;
    cmd_next.restart   = req.restart;
    cmd_next.addend    = w[WEIGHT_BITS-1] ? '0 : w[ADDEND_W-1:0];
    cmd_next.uniform   = req.uniform;
  end

  assign push      = held && !q_full;
  assign push_cmd  = cmd;
  assign req_stall = held && q_full;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

endmodule

[hw/rtl/cdfs_back.sv]
module cdfs_back
  import cdfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  cmd_t head_cmd,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  cmd_t               cmd;
  logic [CNT_W-1:0]   count [2];
  logic [TOTAL_W-1:0] run_total [2];
  logic [63:0]        prod_lo;
  logic [TOTAL_W-1:0] prod_hi;
  logic [TOTAL_W:0]   target;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   mid;
  rsp_t               res;

  logic [CNT_W-1:0]   cur_count;
  logic [TOTAL_W-1:0] cur_total;
  logic [CNT_W-1:0]   base_count;
  logic [TOTAL_W-1:0] base_total;
  logic [TOTAL_W:0]   load_sum;
  logic [TOTAL_W-1:0] new_total;
  logic               full;
  logic               is_load;
  logic               empty;
  logic               less;
  logic [CNT_W-1:0]   lo_n;
  logic [CNT_W-1:0]   hi_n;
  logic [CNT_W-1:0]   mid_n;
  logic [CNT_W-1:0]   mid_first;
  logic [CNT_W-1:0]   found;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [TOTAL_W-1:0] ram_rdata;
  logic               out_free;

  cdfs_ram #(
    .WIDTH(TOTAL_W),
    .DEPTH(2 * MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(new_total),
    .rdata(ram_rdata)
  );

  always_comb begin
    cur_count  = count[cmd.table_sel];
    cur_total  = run_total[cmd.table_sel];
    base_count = cmd.restart ? '0 : cur_count;
    base_total = cmd.restart ? '0 : cur_total;
    load_sum   = {1'b0, base_total} + (TOTAL_W + 1)'(cmd.addend);
    new_total  = load_sum[TOTAL_W] ? TOTAL_MAX : load_sum[TOTAL_W-1:0];
    full       = (base_count >= CNT_W'(MAX_ENTRIES));
    is_load    = (cmd.func == FUNC_LOAD);
    empty      = (cur_count == '0) || (cur_total == '0);

    // One bisection step per cycle on the word read for mid.
    less      = ({1'b0, ram_rdata} < target);
    lo_n      = less ? mid + 1'b1 : lo;
    hi_n      = less ? hi : mid;
    mid_n     = lo_n + ((hi_n - lo_n) >> 1);
    mid_first = cur_count >> 1;
    found     = (lo_n >= cur_count) ? cur_count - 1'b1 : lo_n;

    ram_we   = (state == S_EXEC) && is_load && !full;
    case (state)
      S_EXEC:   ram_addr = {cmd.table_sel, base_count[IDX_W-1:0]};
      S_SUM:    ram_addr = {cmd.table_sel, mid_first[IDX_W-1:0]};
      S_SEARCH: ram_addr = {cmd.table_sel, mid_n[IDX_W-1:0]};
      default:  ram_addr = '0;
    endcase
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign pop      = (state == S_IDLE) && head_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_load || empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (lo_n >= hi_n) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count[0]     <= '0;
      count[1]     <= '0;
      run_total[0] <= '0;
      run_total[1] <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && is_load) begin
        if (!full) begin
          count[cmd.table_sel]     <= base_count + 1'b1;
          run_total[cmd.table_sel] <= new_total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
    case (state)
      S_EXEC: begin
        prod_lo <= 64'(cmd.uniform) * 64'(cur_total[31:0]);
        prod_hi <= TOTAL_W'(cmd.uniform) * TOTAL_W'(cur_total[TOTAL_W-1:32]);
        if (is_load && !full) begin
          res.status <= STATUS_OK;
          res.index  <= base_count[IDX_W-1:0];
          res.total  <= new_total;
        end else begin
          res.index <= '0;
          res.total <= cur_total;
          if (is_load) begin
            res.status <= STATUS_FULL;
          end else if (empty) begin
            res.status <= STATUS_EMPTY;
          end else begin
            res.status <= STATUS_OK;
          end
        end
      end
      S_SUM: begin
        target <= {1'b0, prod_hi} + (TOTAL_W + 1)'(prod_lo[63:32])
                  + (TOTAL_W + 1)'(prod_lo[31:0] != '0);
        lo     <= '0;
        hi     <= cur_count;
        mid    <= mid_first;
      end
      S_SEARCH: begin
        lo  <= lo_n;
        hi  <= hi_n;
        mid <= mid_n;
        if (lo_n >= hi_n) begin
          res.index <= found[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/cdf_weighted_index_sampler.sv]
// Channel   Direction  Handshake                Payload
// request   in         req_valid / req_stall    req (func, table_sel, restart, weight, uniform)
// response  out        rsp_valid / rsp_stall    rsp (index, total, status)
//
// A load item or a flagged sample passes the front register, the queue and the back's EXEC
// and DONE states before its response is registered; a sample item also passes SUM and k
// bisection steps in SEARCH, at most ceil(log2(n + 1)) for n entries. One store read per cycle sets k.
// Reset is synchronous and active high and empties both tables and the command queue.
// The front register and a two-item queue keep taking items while the back works or while
// a finished response waits under rsp_stall.
module cdf_weighted_index_sampler
  import cdfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Classified commands cross from the front to the back through this queue.
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // The front masks the weight to its configured width and turns a non-positive weight
  // into a zero addend, so the back only ever adds.
  cdfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  cdfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // The back holds the counts and totals, appends to the cumulative store, scales the
  // uniform fraction by the total with two registered partial products, and bisects.
  cdfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
